/* src/mvt_pkg.sv */
// shared types and constants of the 4x4 fixed-point matrix vector transform
package mvt_pkg;

   localparam int DIM_DEF       = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_LANES     = 4;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int IDX_W         = 2;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [IDX_W-1:0]         idx_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_XFORM = 1'b1
   } func_type;

   typedef struct packed {
      logic     en;
      idx_type  row;
      idx_type  col;
      data_type value;
   } wr_cmd_type;

endpackage

/* src/mvt_matrix_store.sv */
// matrix entry registers, identity after reset, written one entry at a time
module mvt_matrix_store
   import mvt_pkg::*;
#(
   parameter int DIM       = DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  wr_cmd_type wr_cmd,
   output data_type   mat_o [DIM][DIM]
);

   localparam data_type ONE_FIXED = data_type'(64'(1) << FRAC_BITS);

   data_type mat_ff [DIM][DIM];

   always_ff @(posedge clock) begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            if (reset) begin
               mat_ff[r][c] <= (r == c) ? ONE_FIXED : '0;
            end else if (wr_cmd.en && wr_cmd.row == IDX_W'(r) && wr_cmd.col == IDX_W'(c)) begin
               mat_ff[r][c] <= wr_cmd.value;
            end
         end
      end
   end

   assign mat_o = mat_ff;

   // a write that hits an entry is visible there on the next cycle
   for (genvar r = 0; r < DIM; r++) begin : g_chk_row
      for (genvar c = 0; c < DIM; c++) begin : g_chk_col
         a_write_lands: assert property (@(posedge clock) disable iff (reset)
            (wr_cmd.en && wr_cmd.row == IDX_W'(r) && wr_cmd.col == IDX_W'(c))
            |=> (mat_ff[r][c] == $past(wr_cmd.value)))
            else $error("matrix entry did not take the written value");
      end
   end

endmodule

/* src/mvt_product_stage.sv */
// sixteen parallel 32x32 signed multiplies into a product register
module mvt_product_stage
   import mvt_pkg::*;
#(
   parameter int DIM = DIM_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  data_type vec_i [NUM_LANES],
   input  data_type mat_i [DIM][DIM],
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type prod_o [DIM][DIM]
);

   logic     valid_ff;
   prod_type prod_ff [DIM][DIM];
   prod_type prod_in [DIM][DIM];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            prod_in[r][c] = prod_type'(vec_i[r]) * prod_type'(mat_i[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_o    = prod_ff;

endmodule

/* src/mvt_sum_stage.sv */
// column sums of the products, then floor shift, saturation and result register
module mvt_sum_stage
   import mvt_pkg::*;
#(
   parameter int DIM       = DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type prod_i [DIM][DIM],
   output logic     out_valid,
   input  logic     out_ready,
   output data_type out_data [NUM_LANES],
   output logic     out_sat
);

   logic     sum_valid_ff;
   sum_type  sum_ff [NUM_LANES];
   sum_type  sum_in [NUM_LANES];
   logic     res_valid_ff;
   data_type res_ff [NUM_LANES];
   data_type res_in [NUM_LANES];
   logic     sat_ff;
   logic     sat_in;
   logic     sum_ready;
   logic     lim_hit;
   logic     unused_nz;

   assign sum_ready = !res_valid_ff || out_ready;
   assign in_ready  = !sum_valid_ff || sum_ready;

   for (genvar j = 0; j < NUM_LANES; j++) begin : g_col
      if (j < DIM) begin : g_used
         always_comb begin
            sum_in[j] = '0;
            for (int r = 0; r < DIM; r++) begin
               sum_in[j] = sum_in[j] + sum_type'(prod_i[r][j]);
            end
         end
      end else begin : g_unused
         assign sum_in[j] = '0;
      end
   end

   always_comb begin
      sum_type sh;
      logic    ovf;
      sat_in = 1'b0;
      for (int j = 0; j < NUM_LANES; j++) begin
         // arithmetic shift is the floor division by the fraction scale
         sh  = sum_ff[j] >>> FRAC_BITS;
         ovf = !((&sh[SUM_W-1:DATA_W-1]) || !(|sh[SUM_W-1:DATA_W-1]));
         if (ovf) begin
            res_in[j] = sh[SUM_W-1] ? DATA_MIN : DATA_MAX;
         end else begin
            res_in[j] = sh[DATA_W-1:0];
         end
         sat_in = sat_in | ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            sum_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            res_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sum_ff <= sum_in;
      end
      if (sum_ready && sum_valid_ff) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;
   assign out_sat   = sat_ff;

   always_comb begin
      lim_hit   = 1'b0;
      unused_nz = 1'b0;
      for (int j = 0; j < NUM_LANES; j++) begin
         lim_hit = lim_hit | (res_ff[j] == DATA_MAX) | (res_ff[j] == DATA_MIN);
         if (j >= DIM) begin
            unused_nz = unused_nz | (|res_ff[j]);
         end
      end
   end

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && sat_ff) |-> lim_hit)
      else $error("saturation flagged but no component sits at a limit");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> !unused_nz)
      else $error("component beyond matrix size is not zero");

   a_sum_moves_on: assert property (@(posedge clock) disable iff (reset)
      (sum_valid_ff && sum_ready) |=> res_valid_ff)
      else $error("column sums dropped before the result register");

endmodule

/* src/matrix_vector_transform_4x4.sv */
// top level of the fixed-point 4x4 matrix vector transform
//
// req channel: one transfer per item. req_tuser selects the item kind:
//   write - stores req row/col entry into the matrix, no response
//   transform - multiplies the vector (x,y,z,w) by the matrix, one response
// rsp channel: out component j is the vector dotted with matrix column j,
//   floor-shifted by the fraction bits and clipped to 32 bits; rsp_tuser
//   flags a clip in any component.
// path: a transform accepted on req passes the input register, product register,
//   sum register and result register in turn before it shows on rsp_tvalid.
// throughput: one item per cycle while rsp_tready holds high; the sixteen multipliers work in parallel
//   and each stage is one register deep.
// a write takes effect for every transform accepted after it.
// reset empties all stages and loads the identity matrix.
// when rsp_tready stays low the four stages fill and req_tready drops;
//   bubbles between items are squeezed out as stages drain.
module matrix_vector_transform_4x4
   import mvt_pkg::*;
#(
   parameter int DIM       = DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // row[1:0], col[3:2], entry[35:4], x[67:36], y[99:68], z[131:100],
   // w[163:132], zero pad[167:164]
   input  logic [167:0] req_tdata,
   // func[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   output logic [127:0] rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser
);

   logic       s0_valid_ff;
   func_type   s0_func_ff;
   idx_type    s0_row_ff;
   idx_type    s0_col_ff;
   data_type   s0_entry_ff;
   data_type   s0_vec_ff [NUM_LANES];
   logic       s0_out_ready;
   logic       prod_in_ready;
   logic       prod_valid;
   logic       sum_in_ready;
   wr_cmd_type wr_cmd;
   data_type   mat [DIM][DIM];
   prod_type   prod [DIM][DIM];
   data_type   res [NUM_LANES];
   logic       res_sat;

   // a write retires straight out of the input register
   assign s0_out_ready = (s0_func_ff == FUNC_WRITE) || prod_in_ready;
   assign req_tready   = !s0_valid_ff || s0_out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_func_ff  <= func_type'(req_tuser[0]);
         s0_row_ff   <= req_tdata[1:0];
         s0_col_ff   <= req_tdata[3:2];
         s0_entry_ff <= req_tdata[35:4];
         for (int k = 0; k < NUM_LANES; k++) begin
            s0_vec_ff[k] <= req_tdata[36 + k*DATA_W +: DATA_W];
         end
      end
   end

   assign wr_cmd.en    = s0_valid_ff && (s0_func_ff == FUNC_WRITE);
   assign wr_cmd.row   = s0_row_ff;
   assign wr_cmd.col   = s0_col_ff;
   assign wr_cmd.value = s0_entry_ff;

   mvt_matrix_store #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wr_cmd (wr_cmd),
      .mat_o  (mat)
   );

   mvt_product_stage #(
      .DIM (DIM)
   ) u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff && (s0_func_ff == FUNC_XFORM)),
      .in_ready  (prod_in_ready),
      .vec_i     (s0_vec_ff),
      .mat_i     (mat),
      .out_valid (prod_valid),
      .out_ready (sum_in_ready),
      .prod_o    (prod)
   );

   mvt_sum_stage #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (sum_in_ready),
      .prod_i    (prod),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res),
      .out_sat   (res_sat)
   );

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         rsp_tdata[k*DATA_W +: DATA_W] = res[k];
      end
   end

   assign rsp_tuser[0] = res_sat;

endmodule

/* sim/mvt_vertex_checker.sv */
// checker for the matrix vector transform: tracks the matrix, predicts each vertex, compares
`timescale 1ns / 100ps

module mvt_vertex_checker
   import mvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // row[1:0], col[3:2], entry[35:4], x[67:36], y[99:68], z[131:100],
   // w[163:132], zero pad[167:164]
   input  logic [167:0] req_tdata,
   // func[0]
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   input  logic [127:0] rsp_tdata,
   // saturated[0]
   input  logic [0:0]   rsp_tuser,
   output int           mismatch_total,
   output int           vertices_due
);

   typedef struct {
      data_type comp [NUM_LANES];
      logic     sat;
   } vertex_type;

   data_type   shadow_matrix [NUM_LANES][NUM_LANES];
   vertex_type pending_vertices [$];
   int         mismatches = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // row vector times matrix, floor shift, clip to 32 bits
   function automatic vertex_type transform_vertex(input data_type vx, input data_type vy,
                                                   input data_type vz, input data_type vw);
      vertex_type res;
      data_type   v [NUM_LANES];
      prod_type   prod;
      sum_type    acc;
      sum_type    shifted;
      int         r;
      int         j;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      v[3] = vw;
      res.sat = 1'b0;
      for (j = 0; j < NUM_LANES; j++) begin
         acc = '0;
         for (r = 0; r < NUM_LANES; r++) begin
            prod = v[r] * shadow_matrix[r][j];
            acc  = acc + prod;
         end
         shifted = acc >>> FRAC_BITS_DEF;
         if (shifted > sum_type'(DATA_MAX)) begin
            res.comp[j] = DATA_MAX;
            res.sat     = 1'b1;
         end else if (shifted < sum_type'(DATA_MIN)) begin
            res.comp[j] = DATA_MIN;
            res.sat     = 1'b1;
         end else begin
            res.comp[j] = shifted[DATA_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      vertex_type due;
      data_type   got;
      int         r;
      int         j;
      if (reset) begin
         for (r = 0; r < NUM_LANES; r++)
            for (j = 0; j < NUM_LANES; j++)
               shadow_matrix[r][j] = (r == j) ? data_type'(1 << FRAC_BITS_DEF) : '0;
         pending_vertices.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (func_type'(req_tuser[0]) == FUNC_WRITE)
               shadow_matrix[req_tdata[1:0]][req_tdata[3:2]] = req_tdata[35:4];
            else
               pending_vertices.push_back(transform_vertex(req_tdata[67:36], req_tdata[99:68],
                                                           req_tdata[131:100],
                                                           req_tdata[163:132]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_vertices.size() == 0) begin
               report_mismatch($sformatf("response with none due, data %h", rsp_tdata));
            end else begin
               due = pending_vertices.pop_front();
               for (j = 0; j < NUM_LANES; j++) begin
                  got = rsp_tdata[DATA_W*j +: DATA_W];
                  if (got !== due.comp[j])
                     report_mismatch($sformatf("component %0d want %h got %h",
                                               j, due.comp[j], got));
               end
               if (rsp_tuser[0] !== due.sat)
                  report_mismatch($sformatf("saturated want %b got %b", due.sat, rsp_tuser[0]));
            end
         end
      end
      mismatch_total <= mismatches;
      vertices_due   <= pending_vertices.size();
   end

endmodule

/* sim/matrix_vector_transform_4x4_tb.sv */
// testbench top for the matrix vector transform: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module matrix_vector_transform_4x4_tb;
   import mvt_pkg::*;

   localparam int RANDOM_ITEMS = 1900;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // row[1:0], col[3:2], entry[35:4], x[67:36], y[99:68], z[131:100],
   // w[163:132], zero pad[167:164]
   logic [167:0] req_tdata  = '0;
   // func[0]
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
   logic [127:0] rsp_tdata;
   // saturated[0]
   logic [0:0]   rsp_tuser;

   int mismatch_total;
   int vertices_due;
   bit quiet_run = 1'b0;

   matrix_vector_transform_4x4 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mvt_vertex_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .vertices_due   (vertices_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      return quiet_run ? 0 : $urandom_range(0, 6);
   endfunction

   // matrix entries: mostly small fixed-point values, some extremes and raw words
   function automatic data_type rand_entry();
      data_type small_val;
      small_val = $urandom_range(0, 32'h0008_0000);
      case ($urandom_range(0, 9))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return $urandom;
         3:       return data_type'(1 << FRAC_BITS_DEF);
         4:       return '0;
         default: return small_val - 32'h0004_0000;
      endcase
   endfunction

   function automatic data_type rand_coord();
      data_type small_val;
      small_val = $urandom_range(0, 32'h0200_0000);
      case ($urandom_range(0, 7))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return $urandom;
         3:       return '0;
         default: return small_val - 32'h0100_0000;
      endcase
   endfunction

   task automatic send_item(input func_type f, input idx_type row, input idx_type col,
                            input data_type entry, input data_type x, input data_type y,
                            input data_type z, input data_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {4'b0, w, z, y, x, entry, col, row};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_entry(input idx_type row, input idx_type col, input data_type entry);
      send_item(FUNC_WRITE, row, col, entry, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_vertex(input data_type x, input data_type y,
                              input data_type z, input data_type w);
      send_item(FUNC_XFORM, idx_type'($urandom), idx_type'($urandom), $urandom, x, y, z, w);
   endtask

   // response side: random stalls per transfer
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int n;
      int r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset, extreme components pass through
      send_vertex(DATA_MAX, DATA_MIN, '0, 32'hFFFF_FFFF);
      send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, DATA_MIN + 1);
      // positive and negative clipping in column 0
      write_entry(2'd0, 2'd0, DATA_MAX);
      write_entry(2'd1, 2'd0, DATA_MAX);
      send_vertex(DATA_MAX, DATA_MAX, '0, '0);
      send_vertex(DATA_MIN, DATA_MAX, '0, '0);
      send_vertex(DATA_MIN, DATA_MIN, '0, '0);
      // all four products at their largest, sum needs the full accumulator
      for (r = 0; r < NUM_LANES; r++)
         write_entry(idx_type'(r), 2'd1, DATA_MIN);
      send_vertex(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
      // negative half rounds toward minus infinity
      write_entry(2'd0, 2'd2, 32'h0000_8000);
      send_vertex(32'hFFFF_FFFD, '0, '0, '0);
      // transform with row, col and entry set must not touch the matrix
      send_item(FUNC_XFORM, 2'd3, 2'd3, DATA_MAX, 32'h0000_0003, '0, '0, 32'h0001_0000);
      write_entry(2'd3, 2'd3, '0);
      write_entry(2'd2, 2'd3, DATA_MIN);
      send_vertex(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX);
      send_vertex('0, '0, DATA_MAX, DATA_MAX);
      send_vertex('0, '0, '0, '0);
      send_vertex($urandom, $urandom, $urandom, $urandom);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0)
            quiet_run = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 3)
            write_entry(idx_type'($urandom), idx_type'($urandom), rand_entry());
         else
            send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      req_tvalid <= 1'b0;

      while (vertices_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
